@@ design/vra_pkg.sv @@
// Shared types and constants of the virtual region allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package vra_pkg;

	localparam int ADDR_BITS    = 48;
	localparam int OBJECT_BITS  = 16;
	localparam int PAGES_W      = 37;
	localparam int KIND_W       = 3;
	localparam int STATUS_W     = 3;
	localparam int SLOT_FIELD_W = 6;
	localparam int CFG_IDX_W    = 2;

	localparam logic [ADDR_BITS-1:0] SPACE_START_RST = 48'h0000_0001_0000;
	localparam logic [ADDR_BITS-1:0] SPACE_END_RST   = 48'h8000_0000_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 3'd0,
		KIND_FREE  = 3'd1,
		KIND_FIND  = 3'd2,
		KIND_FAULT = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOSPACE   = 3'd1,
		ST_NOTFOUND  = 3'd2,
		ST_FULL      = 3'd3,
		ST_BADHANDLE = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPACE_START = 2'd0,
		REG_SPACE_END   = 2'd1
	} cfg_reg_t;

	// read address source of the slot tables
	typedef enum logic [2:0] {
		RD_ZERO   = 3'd0,
		RD_RNEXT  = 3'd1,
		RD_PSLOT  = 3'd2,
		RD_HINT   = 3'd3,
		RD_HANDLE = 3'd4
	} rd_src_t;

	// which slot view feeds a result
	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_P    = 2'd1,
		RES_R    = 2'd2,
		RES_NEW  = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic    item_load;
		logic    rd_en;
		rd_src_t rd_src;
		logic    p_load;
		logic    n_clr;
		logic    n_inc;
		logic    from_set_p;
		logic    from_clr;
		logic    fresh_latch;
		logic    fit_save;
		logic    ins_entry;
		logic    ins_link;
		logic    unlink_r;
		logic    unlink_head;
		logic    hint_set;
		logic    emit;
		res_sel_t res_sel;
		status_t res_status;
		logic    res_inside;
		logic    res_last;
	} vra_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  out_free;
		logic  free_avail;
		logic  pages_zero;
		logic  hint_in_space;
		logic  handle_bad;
		logic  fhint_ok;
		logic  r_inside;
		logic  p_inside;
		logic  p_gap;
		logic  loc_stop;
		logic  ff_fit;
		logic  walk_end;
		logic  from_zero;
		logic  clr_empty;
		logic  clr_last;
	} vra_sts_t;

endpackage

@@ design/vra_req_if.sv @@
// Request channel of the allocator: valid/ready plus the request fields.
// Depends on vra_pkg for field widths.
interface vra_req_if;
	import vra_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic [ADDR_BITS-1:0]    address;
	logic [PAGES_W-1:0]      page_count;
	logic [SLOT_FIELD_W-1:0] handle;
	logic [OBJECT_BITS-1:0]  object_id;

	modport source (output valid, kind, address, page_count, handle, object_id, input ready);
	modport sink (input valid, kind, address, page_count, handle, object_id, output ready);
endinterface

@@ design/vra_rsp_if.sv @@
// Result channel of the allocator: valid/ready plus the result fields.
// Depends on vra_pkg for field widths.
interface vra_rsp_if;
	import vra_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [SLOT_FIELD_W-1:0] region_slot;
	logic [ADDR_BITS-1:0]    base_addr;
	logic [PAGES_W-1:0]      region_pages;
	logic [OBJECT_BITS-1:0]  region_object;
	logic                    found_inside;
	logic                    last;

	modport source (output valid, status, region_slot, base_addr, region_pages,
		region_object, found_inside, last, input ready);
	modport sink (input valid, status, region_slot, base_addr, region_pages,
		region_object, found_inside, last, output ready);
endinterface

@@ design/vra_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on vra_pkg for widths.
interface vra_cfg_if;
	import vra_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/vra_ctrl.sv @@
// Controller of the allocator: sequences each request over the slot tables.
// Depends on vra_pkg for the command and status structs.
module vra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  vra_pkg::vra_sts_t sts,
	output vra_pkg::vra_cmd_t cmd
);
	import vra_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_DISPATCH  = 10'b00_0000_0010,
		S_LOAD      = 10'b00_0000_0100,
		S_WALK      = 10'b00_0000_1000,
		S_FLT_HINT  = 10'b00_0001_0000,
		S_FREE      = 10'b00_0010_0000,
		S_CLR_HEAD  = 10'b00_0100_0000,
		S_CLR_STEP  = 10'b00_1000_0000,
		S_INS_ENTRY = 10'b01_0000_0000,
		S_INS_LINK  = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		MODE_LOCATE = 2'd0,
		MODE_FF     = 2'd1,
		MODE_FAULT  = 2'd2
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	// state and walk mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_LOCATE;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	// next state and commands
	always_comb begin
		logic    err_req;
		status_t err_code;
		err_req      = 1'b0;
		err_code     = ST_NOTFOUND;
		cmd          = '0;
		cmd.res_last = 1'b1;
		state_d      = state_q;
		mode_d       = mode_q;
		req_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.kind)
					KIND_ALLOC: begin
						if (!sts.free_avail) begin
							err_req  = 1'b1;
							err_code = ST_FULL;
						end else if (sts.pages_zero) begin
							err_req  = 1'b1;
							err_code = ST_NOSPACE;
						end else begin
							cmd.fresh_latch = 1'b1;
							cmd.from_clr    = 1'b1;
							cmd.rd_en       = 1'b1;
							cmd.rd_src      = RD_ZERO;
							mode_d          = sts.hint_in_space ? MODE_LOCATE : MODE_FF;
							state_d         = S_LOAD;
						end
					end
					KIND_FREE: begin
						if (sts.handle_bad) begin
							err_req  = 1'b1;
							err_code = ST_BADHANDLE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_src = RD_HANDLE;
							state_d    = S_FREE;
						end
					end
					KIND_FIND: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_src = RD_ZERO;
						mode_d     = MODE_LOCATE;
						state_d    = S_LOAD;
					end
					KIND_FAULT: begin
						cmd.rd_en = 1'b1;
						if (sts.fhint_ok) begin
							cmd.rd_src = RD_HINT;
							state_d    = S_FLT_HINT;
						end else begin
							cmd.rd_src = RD_ZERO;
							mode_d     = MODE_FAULT;
							state_d    = S_LOAD;
						end
					end
					KIND_CLEAR: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_src = RD_ZERO;
						state_d    = S_CLR_HEAD;
					end
					default: begin
						err_req  = 1'b1;
						err_code = ST_NOTFOUND;
					end
				endcase
			end
			S_LOAD: begin
				cmd.p_load = 1'b1;
				cmd.n_clr  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_RNEXT;
				state_d    = S_WALK;
			end
			S_WALK: begin
				case (mode_q)
					MODE_LOCATE: begin
						if (sts.walk_end ||
								(!sts.p_inside && !sts.p_gap && sts.loc_stop)) begin
							// no region: find reports it, allocate searches from the start
							if (sts.kind == KIND_FIND) begin
								err_req  = 1'b1;
								err_code = ST_NOTFOUND;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_src = RD_ZERO;
								mode_d     = MODE_FF;
								state_d    = S_LOAD;
							end
						end else if (sts.p_inside || sts.p_gap) begin
							if (sts.kind == KIND_FIND) begin
								if (sts.out_free) begin
									cmd.emit       = 1'b1;
									cmd.res_sel    = RES_P;
									cmd.res_status = ST_OK;
									cmd.res_inside = sts.p_inside;
									state_d        = S_IDLE;
								end
							end else begin
								cmd.from_set_p = 1'b1;
								cmd.rd_en      = 1'b1;
								cmd.rd_src     = RD_PSLOT;
								mode_d         = MODE_FF;
								state_d        = S_LOAD;
							end
						end else begin
							cmd.p_load = 1'b1;
							cmd.n_inc  = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_src = RD_RNEXT;
						end
					end
					MODE_FF: begin
						if (sts.walk_end) begin
							if (!sts.from_zero) begin
								cmd.from_clr = 1'b1;
								cmd.rd_en    = 1'b1;
								cmd.rd_src   = RD_ZERO;
								state_d      = S_LOAD;
							end else begin
								err_req  = 1'b1;
								err_code = ST_NOSPACE;
							end
						end else if (sts.ff_fit) begin
							cmd.fit_save = 1'b1;
							state_d      = S_INS_ENTRY;
						end else begin
							cmd.p_load = 1'b1;
							cmd.n_inc  = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_src = RD_RNEXT;
						end
					end
					MODE_FAULT: begin
						if (sts.walk_end) begin
							err_req  = 1'b1;
							err_code = ST_NOTFOUND;
						end else if (sts.p_inside) begin
							if (sts.out_free) begin
								cmd.hint_set   = 1'b1;
								cmd.emit       = 1'b1;
								cmd.res_sel    = RES_P;
								cmd.res_status = ST_OK;
								state_d        = S_IDLE;
							end
						end else begin
							cmd.p_load = 1'b1;
							cmd.n_inc  = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_src = RD_RNEXT;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_FLT_HINT: begin
				if (sts.r_inside) begin
					if (sts.out_free) begin
						cmd.emit       = 1'b1;
						cmd.res_sel    = RES_R;
						cmd.res_status = ST_OK;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_ZERO;
					mode_d     = MODE_FAULT;
					state_d    = S_LOAD;
				end
			end
			S_FREE: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.res_sel    = RES_R;
					cmd.res_status = ST_OK;
					cmd.unlink_r   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_CLR_HEAD: begin
				if (sts.clr_empty) begin
					err_req  = 1'b1;
					err_code = ST_NOTFOUND;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_RNEXT;
					cmd.n_clr  = 1'b1;
					state_d    = S_CLR_STEP;
				end
			end
			S_CLR_STEP: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.res_sel     = RES_R;
					cmd.res_status  = ST_OK;
					cmd.res_last    = sts.clr_last;
					cmd.unlink_head = 1'b1;
					if (sts.clr_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_src = RD_RNEXT;
						cmd.n_inc  = 1'b1;
					end
				end
			end
			S_INS_ENTRY: begin
				cmd.ins_entry = 1'b1;
				state_d       = S_INS_LINK;
			end
			S_INS_LINK: begin
				if (sts.out_free) begin
					cmd.ins_link   = 1'b1;
					cmd.emit       = 1'b1;
					cmd.res_sel    = RES_NEW;
					cmd.res_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// error results carry no region
		if (err_req && sts.out_free) begin
			cmd.emit       = 1'b1;
			cmd.res_sel    = RES_NONE;
			cmd.res_status = err_code;
			state_d        = S_IDLE;
		end
	end

endmodule

@@ design/vra_dp.sv @@
// Datapath of the allocator: slot tables, walk registers, compares and result register.
// Depends on vra_pkg; driven by vra_ctrl through command and status structs.
module vra_dp #(
	parameter int MAX_SLOTS  = 64,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  vra_pkg::vra_cmd_t                         cmd,
	output vra_pkg::vra_sts_t                         sts,
	input  logic [vra_pkg::KIND_W-1:0]                in_kind,
	input  logic [vra_pkg::ADDR_BITS-1:0]             in_address,
	input  logic [vra_pkg::PAGES_W-1:0]               in_page_count,
	input  logic [vra_pkg::SLOT_FIELD_W-1:0]          in_handle,
	input  logic [vra_pkg::OBJECT_BITS-1:0]           in_object_id,
	input  logic                                      cfg_valid,
	input  logic [vra_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [vra_pkg::ADDR_BITS-1:0]             cfg_data,
	output logic                                      rsp_valid,
	input  logic                                      rsp_ready,
	output logic [vra_pkg::STATUS_W-1:0]              rsp_status,
	output logic [vra_pkg::SLOT_FIELD_W-1:0]          rsp_slot,
	output logic [vra_pkg::ADDR_BITS-1:0]             rsp_base,
	output logic [vra_pkg::PAGES_W-1:0]               rsp_pages,
	output logic [vra_pkg::OBJECT_BITS-1:0]           rsp_object,
	output logic                                      rsp_inside,
	output logic                                      rsp_last
);
	import vra_pkg::*;

	localparam int SW    = $clog2(MAX_SLOTS);
	localparam int CW    = $clog2(MAX_SLOTS + 1);
	localparam int BPW   = ADDR_BITS - PAGE_SHIFT;
	localparam int ENDW  = ((ADDR_BITS > PAGES_W + PAGE_SHIFT) ?
		ADDR_BITS : PAGES_W + PAGE_SHIFT) + 1;
	localparam int DATAW = BPW + PAGES_W + OBJECT_BITS;

	// configuration
	logic [ADDR_BITS-1:0] space_start_q, space_end_q, lo_bound, hi_bound;

	// request fields
	kind_t                   kind_q;
	logic [ADDR_BITS-1:0]    addr_q;
	logic [PAGES_W-1:0]      pages_q;
	logic [SLOT_FIELD_W-1:0] handle_q;
	logic [OBJECT_BITS-1:0]  obj_q;

	// slot tables
	logic [DATAW-1:0] data_mem [MAX_SLOTS];
	logic [SW-1:0]    next_mem [MAX_SLOTS];
	logic [SW-1:0]    prev_mem [MAX_SLOTS];
	logic [DATAW-1:0] rd_data_q;
	logic [SW-1:0]    rd_next_q, rd_prev_q, rd_slot_q, rd_addr;
	logic [MAX_SLOTS-1:0] used_q;
	logic             next0_set_q;

	// write ports
	logic          next_we, prev_we;
	logic [SW-1:0] next_wa, next_wd, prev_wa, prev_wd;

	// read view
	logic [ADDR_BITS-1:0]   r_base;
	logic [ENDW-1:0]        r_end;
	logic [PAGES_W-1:0]     r_pages;
	logic [OBJECT_BITS-1:0] r_obj;
	logic [SW-1:0]          r_next, r_prev;
	logic                   r_sentinel;

	// previous walk entry
	logic [SW-1:0]          p_slot_q;
	logic [ADDR_BITS-1:0]   p_base_q;
	logic [ENDW-1:0]        p_end_q;
	logic [PAGES_W-1:0]     p_pages_q;
	logic [OBJECT_BITS-1:0] p_obj_q;
	logic [CW-1:0]          n_q;

	// allocate bookkeeping
	logic [SW-1:0]        from_q, fresh_q, prec_q, nxs_q, free_slot, hidx;
	logic [ADDR_BITS-1:0] fit_base_q;
	logic                 free_avail;
	logic [ENDW-1:0]      need, addr_w, r_base_w;

	// fault hint
	logic [SW-1:0] hint_slot_q;
	logic          hint_valid_q;

	// result register
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [SLOT_FIELD_W-1:0] out_slot_q;
	logic [ADDR_BITS-1:0]    out_base_q;
	logic [PAGES_W-1:0]      out_pages_q;
	logic [OBJECT_BITS-1:0]  out_obj_q;
	logic                    out_inside_q, out_last_q;

	assign lo_bound = {space_start_q[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign hi_bound = {space_end_q[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_start_q <= SPACE_START_RST;
			space_end_q   <= SPACE_END_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SPACE_START: space_start_q <= cfg_data;
				REG_SPACE_END:   space_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q   <= kind_t'(in_kind);
			addr_q   <= in_address;
			pages_q  <= in_page_count;
			handle_q <= in_handle;
			obj_q    <= in_object_id;
		end
	end

	// read address select
	assign hidx = SW'(handle_q);
	always_comb begin
		case (cmd.rd_src)
			RD_ZERO:   rd_addr = '0;
			RD_RNEXT:  rd_addr = r_next;
			RD_PSLOT:  rd_addr = p_slot_q;
			RD_HINT:   rd_addr = hint_slot_q;
			RD_HANDLE: rd_addr = hidx;
			default:   rd_addr = '0;
		endcase
	end

	// table write ports
	always_comb begin
		next_we = 1'b1;
		prev_we = 1'b1;
		next_wa = r_prev;
		next_wd = r_next;
		prev_wa = r_next;
		prev_wd = r_prev;
		if (cmd.ins_entry) begin
			next_wa = fresh_q;
			next_wd = nxs_q;
			prev_wa = fresh_q;
			prev_wd = prec_q;
		end else if (cmd.ins_link) begin
			next_wa = prec_q;
			next_wd = fresh_q;
			prev_wa = nxs_q;
			prev_wd = fresh_q;
		end else if (cmd.unlink_head) begin
			// clear always removes the region right after the start sentinel
			next_wa = '0;
			prev_wd = '0;
		end else if (!cmd.unlink_r) begin
			next_we = 1'b0;
			prev_we = 1'b0;
		end
	end

	// slot table memories
	always_ff @(posedge clk) begin
		if (cmd.ins_entry) begin
			data_mem[fresh_q] <= {fit_base_q[ADDR_BITS-1:PAGE_SHIFT], pages_q, obj_q};
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (cmd.rd_en) begin
			rd_data_q <= data_mem[rd_addr];
			rd_next_q <= next_mem[rd_addr];
			rd_prev_q <= prev_mem[rd_addr];
		end
	end

	// in-use bits, read slot and start link flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= {{(MAX_SLOTS-2){1'b0}}, 2'b11};
			rd_slot_q   <= '0;
			next0_set_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_slot_q <= rd_addr;
			end
			if (next_we && next_wa == '0) begin
				next0_set_q <= 1'b1;
			end
			if (cmd.ins_entry) begin
				used_q[fresh_q] <= 1'b1;
			end else if (cmd.unlink_r || cmd.unlink_head) begin
				used_q[rd_slot_q] <= 1'b0;
			end
		end
	end

	// slot view; sentinels take their bases from the configuration
	always_comb begin
		r_sentinel = rd_slot_q < SW'(2);
		if (rd_slot_q == SW'(0)) begin
			r_base = lo_bound;
		end else if (rd_slot_q == SW'(1)) begin
			r_base = hi_bound;
		end else begin
			r_base = {rd_data_q[DATAW-1 -: BPW], {PAGE_SHIFT{1'b0}}};
		end
		r_pages = r_sentinel ? '0 : rd_data_q[OBJECT_BITS +: PAGES_W];
		r_obj   = r_sentinel ? '0 : rd_data_q[OBJECT_BITS-1:0];
		r_end   = ENDW'(r_base) + (ENDW'(r_pages) << PAGE_SHIFT);
		r_next  = (rd_slot_q == SW'(0) && !next0_set_q) ? SW'(1) : rd_next_q;
		r_prev  = rd_prev_q;
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_slot_q <= '0;
			n_q      <= '0;
			from_q   <= '0;
		end else begin
			if (cmd.p_load) begin
				p_slot_q <= rd_slot_q;
			end
			if (cmd.n_clr) begin
				n_q <= '0;
			end else if (cmd.n_inc) begin
				n_q <= n_q + CW'(1);
			end
			if (cmd.from_set_p) begin
				from_q <= p_slot_q;
			end else if (cmd.from_clr) begin
				from_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.p_load) begin
			p_base_q  <= r_base;
			p_end_q   <= r_end;
			p_pages_q <= r_pages;
			p_obj_q   <= r_obj;
		end
		if (cmd.fresh_latch) begin
			fresh_q <= free_slot;
		end
		if (cmd.fit_save) begin
			prec_q     <= p_slot_q;
			nxs_q      <= rd_slot_q;
			fit_base_q <= ADDR_BITS'(p_end_q);
		end
	end

	// lowest free slot above the sentinels
	always_comb begin
		free_avail = 1'b0;
		free_slot  = '0;
		for (int i = MAX_SLOTS - 1; i >= 2; i--) begin
			if (!used_q[i]) begin
				free_avail = 1'b1;
				free_slot  = SW'(i);
			end
		end
	end

	// fault hint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_slot_q  <= '0;
			hint_valid_q <= 1'b0;
		end else if (cmd.unlink_r || cmd.unlink_head) begin
			hint_slot_q  <= '0;
			hint_valid_q <= 1'b0;
		end else if (cmd.hint_set) begin
			hint_slot_q  <= p_slot_q;
			hint_valid_q <= 1'b1;
		end
	end

	// compares for the controller
	assign need     = ENDW'(pages_q) << PAGE_SHIFT;
	assign addr_w   = ENDW'(addr_q);
	assign r_base_w = ENDW'(r_base);

	always_comb begin
		sts               = '0;
		sts.kind          = kind_q;
		sts.out_free      = !out_valid_q || rsp_ready;
		sts.free_avail    = free_avail;
		sts.pages_zero    = pages_q == '0;
		sts.hint_in_space = addr_q != '0 && addr_q >= lo_bound && addr_q < hi_bound;
		sts.handle_bad    = handle_q < SLOT_FIELD_W'(2) || 32'(handle_q) >= MAX_SLOTS ||
			!used_q[hidx];
		sts.fhint_ok      = hint_valid_q && hint_slot_q >= SW'(2) && used_q[hint_slot_q];
		sts.r_inside      = r_base <= addr_q && addr_w < r_end;
		sts.p_inside      = p_base_q <= addr_q && addr_w < p_end_q;
		sts.p_gap         = p_end_q <= addr_w && addr_q < r_base;
		sts.loc_stop      = r_base > addr_q;
		sts.ff_fit        = r_base_w >= p_end_q && (r_base_w - p_end_q) >= need;
		sts.walk_end      = p_slot_q == SW'(1) || n_q == CW'(MAX_SLOTS);
		sts.from_zero     = from_q == '0;
		sts.clr_empty     = r_next == SW'(0) || r_next == SW'(1);
		sts.clr_last      = sts.clr_empty || n_q == CW'(MAX_SLOTS - 1);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.res_status;
			out_inside_q <= cmd.res_inside;
			out_last_q   <= cmd.res_last;
			case (cmd.res_sel)
				RES_P: begin
					out_slot_q  <= SLOT_FIELD_W'(p_slot_q);
					out_base_q  <= p_base_q;
					out_pages_q <= p_pages_q;
					out_obj_q   <= p_obj_q;
				end
				RES_R: begin
					out_slot_q  <= SLOT_FIELD_W'(rd_slot_q);
					out_base_q  <= r_base;
					out_pages_q <= r_pages;
					out_obj_q   <= r_obj;
				end
				RES_NEW: begin
					out_slot_q  <= SLOT_FIELD_W'(fresh_q);
					out_base_q  <= {fit_base_q[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
					out_pages_q <= pages_q;
					out_obj_q   <= obj_q;
				end
				default: begin
					out_slot_q  <= '0;
					out_base_q  <= '0;
					out_pages_q <= '0;
					out_obj_q   <= '0;
				end
			endcase
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot   = out_slot_q;
	assign rsp_base   = out_base_q;
	assign rsp_pages  = out_pages_q;
	assign rsp_object = out_obj_q;
	assign rsp_inside = out_inside_q;
	assign rsp_last   = out_last_q;

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || rsp_ready))
		else $error("result loaded over an untaken result");
	a_sentinels: assert property (@(posedge clk) disable iff (!arst_n)
		used_q[0] && used_q[1])
		else $error("sentinel slot marked free");
	a_hint_used: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid_q |-> used_q[hint_slot_q])
		else $error("fault hint points at a free slot");
	a_link_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_link |-> used_q[fresh_q])
		else $error("linking a slot that was not claimed");
`endif

endmodule

@@ design/virtual_region_allocator.sv @@
// Free reads its slot directly; find, fault lookup and allocate walk the linked table,
// and clear all removes the regions one by one; one request at a time.
// Rate is set by the linked-table walk: one slot per cycle through the single read port.
// Reset is asynchronous: sentinels linked, all other slots free, fault hint cleared;
// slot table memories are not cleared, no clearing pass is needed.
module virtual_region_allocator #(
	parameter int MAX_SLOTS  = 64,
	parameter int PAGE_SHIFT = 12
) (
	input logic      clk,
	input logic      arst_n,
	vra_req_if.sink  req,
	vra_rsp_if.source rsp,
	vra_cfg_if.sink  cfg
);
	import vra_pkg::*;

	vra_cmd_t cmd;
	vra_sts_t sts;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	vra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vra_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_kind       (req.kind),
		.in_address    (req.address),
		.in_page_count (req.page_count),
		.in_handle     (req.handle),
		.in_object_id  (req.object_id),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_status    (rsp.status),
		.rsp_slot      (rsp.region_slot),
		.rsp_base      (rsp.base_addr),
		.rsp_pages     (rsp.region_pages),
		.rsp_object    (rsp.region_object),
		.rsp_inside    (rsp.found_inside),
		.rsp_last      (rsp.last)
	);

endmodule
